FILE: hw/rtl/mac_keyed_key_table_core_macros.svh
// Assertion macros for the keyed key table core.
`ifndef MAC_KEYED_KEY_TABLE_CORE_MACROS_SVH
`define MAC_KEYED_KEY_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MKT_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MKT_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define MKT_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define MKT_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

FILE: hw/rtl/mkt_pkg.sv
// ----------------------------------------------------------------------------
// mkt_pkg
// Shared types and codes for the keyed key table.
// ----------------------------------------------------------------------------
package mkt_pkg;

    // Operation codes.
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // One queued request between front and back.
    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] mac;
        logic [63:0] key_high;
        logic [63:0] key_low;
    } req_t;

endpackage

FILE: hw/rtl/mkt_front.sv
// ----------------------------------------------------------------------------
// mkt_front
// Input side: a two-entry request queue that accepts transactions while the
// back end is busy scanning.
// ----------------------------------------------------------------------------
module mkt_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mkt_pkg::req_t  in_req,
    output logic           q_valid,
    input  logic           q_ready,
    output mkt_pkg::req_t  q_req
);

    mkt_pkg::req_t  buf_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

FILE: hw/rtl/mkt_back.sv
// ----------------------------------------------------------------------------
// mkt_back
// Execution side: scans the table one slot per cycle, then applies the
// operation and holds the result in an output register.
// ----------------------------------------------------------------------------
module mkt_back #(
    parameter int ENTRIES = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  mkt_pkg::req_t  q_req,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [3:0]     m_slot,
    output logic [63:0]    m_found_key_high,
    output logic [63:0]    m_found_key_low,
    output logic [4:0]     m_entry_count
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW:0] LAST = (IW + 1)'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg;
    logic [47:0]    addr_mem [ENTRIES];
    logic [127:0]   key_mem  [ENTRIES];
    logic [CW-1:0]  count_reg;
    mkt_pkg::req_t  req_reg;
    logic [IW:0]    idx_reg;
    logic           hit_reg, free_reg;
    logic [IW-1:0]  hit_idx_reg, free_idx_reg;
    logic [47:0]    addr_rd_reg;
    logic           scan_vld_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic           out_vld_reg;
    logic [1:0]     status_reg;
    logic [3:0]     slot_reg;
    logic [127:0]   okey_reg;
    logic [4:0]     ocount_reg;
    logic           out_free;

    assign out_free  = !out_vld_reg || m_ready;
    assign q_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_vld_reg;
    assign m_status  = status_reg;
    assign m_slot    = slot_reg;
    assign m_found_key_high = okey_reg[127:64];
    assign m_found_key_low  = okey_reg[63:0];
    assign m_entry_count    = ocount_reg;

    // Sequencer: idle, scan every slot, then commit once the output is free.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_SCAN;
            S_SCAN: if (scan_vld_reg && rd_idx_reg == LAST[IW-1:0] &&
                        idx_reg > LAST) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Address memory read, one slot per cycle, registered.
    always_ff @(posedge aclk) begin
        addr_rd_reg <= addr_mem[idx_reg[IW-1:0]];
        rd_idx_reg  <= idx_reg[IW-1:0];
        if (q_valid && q_ready) begin
            req_reg <= q_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            scan_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_vld_reg && m_ready && state_reg != S_DONE) out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    idx_reg      <= '0;
                    scan_vld_reg <= 1'b0;
                    hit_reg      <= 1'b0;
                    free_reg     <= 1'b0;
                end
                S_SCAN: begin
                    if (idx_reg <= LAST) idx_reg <= idx_reg + 1'b1;
                    scan_vld_reg <= (idx_reg <= LAST);
                    if (scan_vld_reg) begin
                        if (!hit_reg && valid_reg[rd_idx_reg] &&
                            addr_rd_reg == req_reg.mac) begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                        end
                        if (!free_reg && !valid_reg[rd_idx_reg]) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_vld_reg <= 1'b1;
                        if (req_reg.mode == mkt_pkg::MODE_ADD && !hit_reg && free_reg) begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                        end else if (req_reg.mode == mkt_pkg::MODE_REMOVE && hit_reg) begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result and table payload writes at commit.
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            status_reg <= mkt_pkg::ST_MISS;
            slot_reg   <= '0;
            okey_reg   <= '0;
            ocount_reg <= 5'(count_reg);
            priority if (req_reg.mode == mkt_pkg::MODE_LOOKUP) begin
                if (hit_reg) begin
                    status_reg <= mkt_pkg::ST_HIT;
                    slot_reg   <= 4'(hit_idx_reg);
                    okey_reg   <= key_mem[hit_idx_reg];
                end
            end else if (req_reg.mode == mkt_pkg::MODE_ADD) begin
                if (hit_reg) begin
                    status_reg <= mkt_pkg::ST_HIT;
                    slot_reg   <= 4'(hit_idx_reg);
                    key_mem[hit_idx_reg] <= {req_reg.key_high, req_reg.key_low};
                end else if (free_reg) begin
                    status_reg <= mkt_pkg::ST_NEW;
                    slot_reg   <= 4'(free_idx_reg);
                    ocount_reg <= 5'(count_reg + 1'b1);
                    addr_mem[free_idx_reg] <= req_reg.mac;
                    key_mem[free_idx_reg]  <= {req_reg.key_high, req_reg.key_low};
                end else begin
                    status_reg <= mkt_pkg::ST_FULL;
                end
            end else if (req_reg.mode == mkt_pkg::MODE_REMOVE) begin
                if (hit_reg) begin
                    status_reg <= mkt_pkg::ST_HIT;
                    slot_reg   <= 4'(hit_idx_reg);
                    ocount_reg <= 5'(count_reg - 1'b1);
                end
            end else begin
                status_reg <= mkt_pkg::ST_MISS;
            end
        end
    end

endmodule

FILE: hw/rtl/mac_keyed_key_table_core.sv
// ----------------------------------------------------------------------------
// mac_keyed_key_table_core
// Associative table of device addresses and 128-bit keys.
// ----------------------------------------------------------------------------
// Usage: requests (mode, mac, key) enter on the s_ valid/ready channel; one
// result per request leaves on the m_ channel. A two-entry request queue
// takes new transactions while the back end works.
// Scan: each request scans all ENTRIES slots, one per cycle through the
// registered address memory read, before the result is committed to the
// output register; the back end takes no new request until that result
// is committed.
// The scan unit is the limit on rate.
// Reset empties the table at once: valid bits and the entry count clear,
// stored addresses and keys are not read until rewritten.
// When the receiver stalls, the result waits in the output register, the
// back end holds its finished request, and the front queue fills, then
// drops s_ready.
// ----------------------------------------------------------------------------
`include "mac_keyed_key_table_core_macros.svh"
module mac_keyed_key_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [47:0] s_mac,
    input  logic [63:0] s_key_high,
    input  logic [63:0] s_key_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_slot,
    output logic [63:0] m_found_key_high,
    output logic [63:0] m_found_key_low,
    output logic [4:0]  m_entry_count
);

    mkt_pkg::req_t in_req, q_req;
    logic          q_valid, q_ready;

    assign in_req = '{mode: s_mode, mac: s_mac, key_high: s_key_high, key_low: s_key_low};

    mkt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    mkt_back #(.ENTRIES(ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_slot(m_slot), .m_found_key_high(m_found_key_high),
        .m_found_key_low(m_found_key_low), .m_entry_count(m_entry_count)
    );

    // A full-table result never reports a slot other than zero.
    `MKT_ASSERT_IMPL(a_full_slot, aclk, aresetn, (m_valid && m_status == mkt_pkg::ST_FULL) |-> (m_slot == 4'd0), "full result with nonzero slot")
    // A non-hit result (miss, new or full) never returns key bits.
    `MKT_ASSERT_IMPL(a_miss_key, aclk, aresetn, (m_valid && m_status != mkt_pkg::ST_HIT) |-> (m_found_key_high == 64'd0 && m_found_key_low == 64'd0), "key bits on non-hit")
    // A stalled result stays valid and holds its count.
    `MKT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_entry_count), "stalled result changed")

endmodule
